FILE: rtl/core/mjgs_pkg.sv
`default_nettype none

package mjgs_pkg;

	localparam int unsigned KEY_W = 64;
	localparam int unsigned CNT_W = 32;
	localparam int unsigned THR_W = 63;
	localparam int unsigned PROD_W = 2 * CNT_W;
	localparam int unsigned STEP_W = $clog2(CNT_W);

	localparam logic [THR_W-1:0] THR_RESET = 63'd1000000000000;

	typedef struct packed {
		logic             first_pair;
		logic [KEY_W-1:0] left_key;
		logic [CNT_W-1:0] left_count;
		logic [KEY_W-1:0] right_key;
		logic [CNT_W-1:0] right_start;
		logic [CNT_W-1:0] right_count;
	} in_t;

	typedef struct packed {
		logic             advance_left;
		logic             advance_right;
		logic             part_valid;
		logic [CNT_W-1:0] part_begin;
		logic [CNT_W-1:0] part_stop;
		logic [CNT_W-1:0] part_size;
		logic [CNT_W-1:0] match_index;
		logic             last_of_run;
		logic             parts_capped;
	} out_t;

	typedef enum logic [1:0] {
		KIND_MISS  = 2'd0,
		KIND_WHOLE = 2'd1,
		KIND_PART  = 2'd2
	} out_kind_t;

	typedef struct packed {
		logic      accept;
		logic      mul;
		logic      qdiv_start;
		logic      qdiv_step;
		logic      n_set;
		logic      rdiv_step;
		logic      load_out;
		out_kind_t kind;
		logic      inc_match;
	} ctl_cmd_t;

	typedef struct packed {
		logic key_eq;
		logic prod_le;
		logic qdiv_last;
		logic rdiv_last;
		logic part_last;
	} dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/merge_join_group_splitter.sv
// key mismatch or unsplit match: after the multiply state the result is loaded in the evaluate state, then idle
// split match: a multiply and two bit-serial divisions (part count, then part size) before the
// first part, then one part per cycle while the result side takes them
// a new transaction is taken once the last result of the previous one is in the output register
// reset clears the controller, the output valid and the match index, and sets the threshold to 1e12
`default_nettype none

module merge_join_group_splitter #(
	parameter int unsigned MAX_PARTS = 64
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          step_valid,
	output logic                         step_ready,
	input  mjgs_pkg::in_t                step,
	output logic                         res_valid,
	input  wire                          res_ready,
	output mjgs_pkg::out_t               res,
	input  wire                          cfg_wr_en,
	input  wire  [mjgs_pkg::THR_W-1:0]   cfg_wr_data
);
	import mjgs_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;

	mjgs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_valid (step_valid),
		.step_ready (step_ready),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	mjgs_dp #(
		.MAX_PARTS (MAX_PARTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.stat        (stat),
		.res         (res)
	);

endmodule

`default_nettype wire

FILE: rtl/core/mjgs_ctrl.sv
`default_nettype none

module mjgs_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 step_valid,
	output logic                step_ready,
	output logic                res_valid,
	input  wire                 res_ready,
	input  mjgs_pkg::dp_stat_t  stat,
	output mjgs_pkg::ctl_cmd_t  cmd
);
	import mjgs_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_MUL  = 7'b0000010,
		S_EVAL = 7'b0000100,
		S_QDIV = 7'b0001000,
		S_NSET = 7'b0010000,
		S_RDIV = 7'b0100000,
		S_PART = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free   = !out_valid_q || res_ready;
	assign step_ready = (state_q == S_IDLE);
	assign res_valid  = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.kind = KIND_MISS;
		unique case (state_q)
			S_IDLE: begin
				if (step_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_EVAL;
			end
			S_EVAL: begin
				if (!stat.key_eq) begin
					if (out_free) begin
						cmd.load_out = 1'b1;
						cmd.kind     = KIND_MISS;
						state_d      = S_IDLE;
					end
				end else if (stat.prod_le) begin
					if (out_free) begin
						cmd.load_out  = 1'b1;
						cmd.kind      = KIND_WHOLE;
						cmd.inc_match = 1'b1;
						state_d       = S_IDLE;
					end
				end else begin
					cmd.qdiv_start = 1'b1;
					state_d        = S_QDIV;
				end
			end
			S_QDIV: begin
				cmd.qdiv_step = 1'b1;
				if (stat.qdiv_last) begin
					state_d = S_NSET;
				end
			end
			S_NSET: begin
				cmd.n_set = 1'b1;
				state_d   = S_RDIV;
			end
			S_RDIV: begin
				cmd.rdiv_step = 1'b1;
				if (stat.rdiv_last) begin
					state_d = S_PART;
				end
			end
			S_PART: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					cmd.kind     = KIND_PART;
					if (stat.part_last) begin
						cmd.inc_match = 1'b1;
						state_d       = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |-> !cmd.load_out)
		else $error("result register overwritten while stalled");

	a_accept_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		step_valid && step_ready |=> state_q == S_MUL)
		else $error("accepted transaction did not enter multiply");

	a_last_part_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PART && cmd.load_out && stat.part_last |=> state_q == S_IDLE)
		else $error("split did not finish after last part");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> res_valid)
		else $error("loaded result not presented");

endmodule

`default_nettype wire

FILE: rtl/core/mjgs_dp.sv
`default_nettype none

module mjgs_dp #(
	parameter int unsigned MAX_PARTS = 64
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  mjgs_pkg::in_t                     step,
	input  wire                               cfg_wr_en,
	input  wire  [mjgs_pkg::THR_W-1:0]        cfg_wr_data,
	input  mjgs_pkg::ctl_cmd_t                cmd,
	output mjgs_pkg::dp_stat_t                stat,
	output mjgs_pkg::out_t                    res
);
	import mjgs_pkg::*;

	localparam int unsigned QW  = $clog2(MAX_PARTS) + 1;
	localparam int unsigned NW  = $clog2(MAX_PARTS + 1);
	localparam int unsigned DVW = THR_W + QW - 1;
	localparam int unsigned CW  = (DVW > PROD_W) ? DVW : PROD_W;

	in_t               in_q;
	logic [THR_W-1:0]  thr_q;
	logic [THR_W-1:0]  thr_eff;
	logic [CNT_W-1:0]  match_q;
	logic [PROD_W-1:0] prod_q;
	logic              eq_q;
	logic              lt_q;
	logic [PROD_W-1:0] qrem_q;
	logic [DVW-1:0]    dvs_q;
	logic [QW-1:0]     quo_q;
	logic [STEP_W-1:0] step_q;
	logic [NW-1:0]     n_q;
	logic              capped_q;
	logic [CNT_W-1:0]  rquo_q;
	logic [NW-1:0]     rrem_q;
	logic [NW-1:0]     p_q;
	logic [CNT_W-1:0]  off_q;
	out_t              res_q;

	logic              q_ge;
	logic [CW-1:0]     q_diff;
	logic              n_capped;
	logic [NW:0]       r_t;
	logic              r_ge;
	logic [CNT_W-1:0]  sz;
	logic [CNT_W-1:0]  pbeg;
	out_t              res_d;

	assign thr_eff = (thr_q == '0) ? THR_W'(1) : thr_q;

	assign q_ge     = CW'(qrem_q) >= CW'(dvs_q);
	assign q_diff   = CW'(qrem_q) - CW'(dvs_q);
	assign n_capped = quo_q >= QW'(MAX_PARTS);

	assign r_t  = {rrem_q, rquo_q[CNT_W-1]};
	assign r_ge = r_t >= {1'b0, n_q};

	assign sz   = rquo_q + ((p_q < rrem_q) ? CNT_W'(1) : CNT_W'(0));
	assign pbeg = in_q.right_start + off_q;

	assign stat.key_eq    = eq_q;
	assign stat.prod_le   = prod_q <= PROD_W'(thr_eff);
	assign stat.qdiv_last = step_q == STEP_W'(QW - 1);
	assign stat.rdiv_last = step_q == STEP_W'(CNT_W - 1);
	assign stat.part_last = NW'(p_q + 1'b1) == n_q;

	always_comb begin
		res_d = '0;
		case (cmd.kind)
			KIND_WHOLE: begin
				res_d.advance_left  = 1'b1;
				res_d.advance_right = 1'b1;
				res_d.part_valid    = 1'b1;
				res_d.part_begin    = in_q.right_start;
				res_d.part_stop     = in_q.right_start + in_q.right_count;
				res_d.part_size     = in_q.right_count;
				res_d.match_index   = match_q;
				res_d.last_of_run   = 1'b1;
			end
			KIND_PART: begin
				res_d.advance_left  = 1'b1;
				res_d.advance_right = 1'b1;
				res_d.part_valid    = 1'b1;
				res_d.part_begin    = pbeg;
				res_d.part_stop     = pbeg + sz;
				res_d.part_size     = sz;
				res_d.match_index   = match_q;
				res_d.last_of_run   = stat.part_last;
				res_d.parts_capped  = capped_q;
			end
			default: begin
				res_d.advance_left  = lt_q;
				res_d.advance_right = !lt_q;
				res_d.last_of_run   = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= THR_RESET;
			match_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				thr_q <= cfg_wr_data;
			end
			if (cmd.accept && step.first_pair) begin
				match_q <= '0;
			end else if (cmd.inc_match) begin
				match_q <= match_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			in_q <= step;
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(in_q.left_count) * PROD_W'(in_q.right_count);
			eq_q   <= in_q.left_key == in_q.right_key;
			lt_q   <= in_q.left_key < in_q.right_key;
		end
		if (cmd.qdiv_start) begin
			qrem_q <= prod_q - 1'b1;
			dvs_q  <= DVW'(thr_eff) << (QW - 1);
			quo_q  <= '0;
			step_q <= '0;
		end
		if (cmd.qdiv_step) begin
			if (q_ge) begin
				qrem_q <= PROD_W'(q_diff);
			end
			dvs_q  <= dvs_q >> 1;
			quo_q  <= QW'({quo_q, q_ge});
			step_q <= step_q + 1'b1;
		end
		if (cmd.n_set) begin
			n_q      <= n_capped ? NW'(MAX_PARTS) : NW'({1'b0, quo_q} + 1'b1);
			capped_q <= n_capped;
			rquo_q   <= in_q.right_count;
			rrem_q   <= '0;
			step_q   <= '0;
			p_q      <= '0;
			off_q    <= '0;
		end
		if (cmd.rdiv_step) begin
			rrem_q <= r_ge ? NW'(r_t - {1'b0, n_q}) : NW'(r_t);
			rquo_q <= {rquo_q[CNT_W-2:0], r_ge};
			step_q <= step_q + 1'b1;
		end
		if (cmd.load_out && cmd.kind == KIND_PART) begin
			off_q <= off_q + sz;
			p_q   <= p_q + 1'b1;
		end
		if (cmd.load_out) begin
			res_q <= res_d;
		end
	end

	assign res = res_q;

endmodule

`default_nettype wire

FILE: test/mjgs_join_checker.sv
`default_nettype none

module mjgs_join_checker #(
	parameter int unsigned MAX_PARTS = 64
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          step_valid,
	input  wire                          step_ready,
	input  mjgs_pkg::in_t                step,
	input  wire                          res_valid,
	input  wire                          res_ready,
	input  mjgs_pkg::out_t               res,
	input  wire                          cfg_wr_en,
	input  wire  [mjgs_pkg::THR_W-1:0]   cfg_wr_data,
	output int                           fail_count,
	output int                           outstanding,
	output int                           result_count,
	output int                           split_count,
	output int                           capped_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import mjgs_pkg::*;

	out_t             due_parts[$];
	out_t             want;
	logic [THR_W-1:0] work_limit;
	logic [CNT_W-1:0] match_count;

	function automatic void split_group(input in_t s);
		logic [PROD_W-1:0] limit, prod, nparts, base, rem, p, off, sz;
		logic              capped;
		out_t              r;
		r = '0;
		if (s.first_pair)
			match_count = '0;
		if (s.left_key != s.right_key) begin
			r.advance_left = s.left_key < s.right_key;
			r.advance_right = ~r.advance_left;
			r.last_of_run = 1'b1;
			due_parts.push_back(r);
			return;
		end
		limit = {1'b0, work_limit};
		if (limit == 0)
			limit = 1;
		prod = PROD_W'(s.left_count) * PROD_W'(s.right_count);
		r.advance_left = 1'b1;
		r.advance_right = 1'b1;
		r.part_valid = 1'b1;
		r.match_index = match_count;
		match_count = match_count + 1'b1;
		if (prod <= limit) begin
			r.part_begin = s.right_start;
			r.part_size = s.right_count;
			r.part_stop = s.right_start + s.right_count;
			r.last_of_run = 1'b1;
			due_parts.push_back(r);
			return;
		end
		nparts = prod / limit + ((prod % limit) != 0);
		capped = nparts > MAX_PARTS;
		if (capped)
			nparts = MAX_PARTS;
		split_count++;
		if (capped)
			capped_count++;
		base = PROD_W'(s.right_count) / nparts;
		rem = PROD_W'(s.right_count) % nparts;
		r.parts_capped = capped;
		for (p = 0; p < nparts; p++) begin
			off = p * base + ((p < rem) ? p : rem);
			sz = base + (p < rem);
			r.part_begin = s.right_start + off[CNT_W-1:0];
			r.part_size = sz[CNT_W-1:0];
			r.part_stop = r.part_begin + r.part_size;
			r.last_of_run = (p + 1 == nparts);
			due_parts.push_back(r);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_limit = THR_RESET;
			match_count = '0;
			due_parts.delete();
		end else begin
			if (cfg_wr_en)
				work_limit = cfg_wr_data;
			if (res_valid && res_ready) begin
				result_count++;
				if (due_parts.size() == 0) begin
					if (fail_count < 10)
						$display("tb: result %0d arrived with nothing due: %h", result_count, res);
					fail_count++;
				end else begin
					want = due_parts.pop_front();
					if (res.advance_left !== want.advance_left ||
					    res.advance_right !== want.advance_right ||
					    res.part_valid !== want.part_valid ||
					    res.part_begin !== want.part_begin ||
					    res.part_stop !== want.part_stop ||
					    res.part_size !== want.part_size ||
					    res.match_index !== want.match_index ||
					    res.last_of_run !== want.last_of_run ||
					    res.parts_capped !== want.parts_capped) begin
						if (fail_count < 10) begin
							$display("tb: result %0d mismatch", result_count);
							$display("  expected al=%b ar=%b pv=%b begin=%h stop=%h size=%h idx=%h last=%b cap=%b",
							         want.advance_left, want.advance_right, want.part_valid,
							         want.part_begin, want.part_stop, want.part_size,
							         want.match_index, want.last_of_run, want.parts_capped);
							$display("  actual   al=%b ar=%b pv=%b begin=%h stop=%h size=%h idx=%h last=%b cap=%b",
							         res.advance_left, res.advance_right, res.part_valid,
							         res.part_begin, res.part_stop, res.part_size,
							         res.match_index, res.last_of_run, res.parts_capped);
						end
						fail_count++;
					end
				end
			end
			if (step_valid && step_ready)
				split_group(step);
		end
		outstanding = due_parts.size();
	end

endmodule

`default_nettype wire

FILE: test/testbench.sv
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import mjgs_pkg::*;

	localparam int unsigned PARTS_MAX = 64;
	localparam int unsigned QUIET_LIMIT = 5000;
	localparam int unsigned PHASE_STEPS = 30;

	logic             clk;
	logic             arst_n;
	logic             step_valid;
	logic             step_ready;
	in_t              step;
	logic             res_valid;
	logic             res_ready;
	out_t             res;
	logic             cfg_wr_en;
	logic [THR_W-1:0] cfg_wr_data;

	int               fail_count, outstanding, result_count, split_count, capped_count;
	int unsigned      send_idle, recv_stall, quiet, steps_sent;
	logic [KEY_W-1:0] left_head, right_head;
	int unsigned      left_groups, right_groups;
	logic [THR_W-1:0] limits [8];

	merge_join_group_splitter #(
		.MAX_PARTS(PARTS_MAX)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_valid  (step_valid),
		.step_ready  (step_ready),
		.step        (step),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	mjgs_join_checker #(
		.MAX_PARTS(PARTS_MAX)
	) checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_valid   (step_valid),
		.step_ready   (step_ready),
		.step         (step),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.fail_count   (fail_count),
		.outstanding  (outstanding),
		.result_count (result_count),
		.split_count  (split_count),
		.capped_count (capped_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(negedge clk)
		res_ready <= ($urandom_range(0, 99) >= recv_stall);

	always @(posedge clk) begin
		if (!arst_n || (step_valid && step_ready) || (res_valid && res_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	function automatic logic [CNT_W-1:0] pick_count();
		case ($urandom_range(0, 9)) inside
			0: return '0;
			1: return '1;
			2: return $urandom;
			[3:5]: return $urandom_range(1, 10);
			default: return $urandom_range(1, 5000);
		endcase
	endfunction

	task automatic drive_pair(input logic first, input logic [KEY_W-1:0] lk,
	                          input logic [CNT_W-1:0] lc, input logic [KEY_W-1:0] rk,
	                          input logic [CNT_W-1:0] rs, input logic [CNT_W-1:0] rc);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle) begin
			step_valid <= 1'b0;
			@(negedge clk);
		end
		step_valid <= 1'b1;
		step <= '{first_pair: first, left_key: lk, left_count: lc,
		          right_key: rk, right_start: rs, right_count: rc};
		@(posedge clk);
		while (!step_ready)
			@(posedge clk);
		steps_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		step_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic set_limit(input logic [THR_W-1:0] value);
		wait_drained();
		repeat (8) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// mostly well-formed merges over two sorted group lists, the rest loose pairs
	task automatic run_phase(input int unsigned n);
		logic             first;
		logic [KEY_W-1:0] lk, rk;
		int unsigned      i;
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				first = 1'($urandom_range(0, 1));
				lk = {$urandom, $urandom};
				rk = $urandom_range(0, 1) ? lk : {$urandom, $urandom};
			end else begin
				first = (left_groups == 0 || right_groups == 0);
				if (first) begin
					left_head = {$urandom, $urandom} >> 1;
					right_head = left_head + $urandom_range(0, 2);
					left_groups = $urandom_range(3, 12);
					right_groups = $urandom_range(3, 12);
				end
				lk = left_head;
				rk = right_head;
				if (lk <= rk) begin
					left_head = left_head + $urandom_range(1, 3);
					left_groups--;
				end
				if (rk <= lk) begin
					right_head = right_head + $urandom_range(1, 3);
					right_groups--;
				end
			end
			drive_pair(first, lk, pick_count(), rk,
			           ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 50)
			                                       : $urandom,
			           pick_count());
		end
	endtask

	initial begin : stimulus
		int unsigned phase;
		limits = '{63'd1, 63'd0, 63'd37, 63'd5000, 63'd1000000, {THR_W{1'b1}},
		           THR_W'({$urandom, $urandom}), THR_RESET};
		arst_n = 1'b0;
		step_valid = 1'b0;
		step = '0;
		res_ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		send_idle = 0;
		recv_stall = 0;
		quiet = 0;
		steps_sent = 0;
		left_groups = 0;
		right_groups = 0;
		left_head = '0;
		right_head = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed, at the reset threshold
		drive_pair(1'b1, '0, 5, '1, 7, 9);
		drive_pair(1'b0, '1, 5, '0, 7, 9);
		drive_pair(1'b0, 64'h8000_0000_0000_0000, 1, 64'h7FFF_FFFF_FFFF_FFFF, 0, 1);
		drive_pair(1'b0, 64'h1234_5678_0000_0000, 1, 64'h1234_5678_0000_0001, 0, 1);
		drive_pair(1'b0, '0, 1, '0, 0, 1);
		drive_pair(1'b0, '1, 0, '1, '1, '1);
		drive_pair(1'b0, 64'h5555_5555_5555_5555, '1, 64'h5555_5555_5555_5555, 32'h10, 0);
		drive_pair(1'b0, 64'hAAAA_AAAA_AAAA_AAAA, 1000000, 64'hAAAA_AAAA_AAAA_AAAA, 100, 1000000);
		drive_pair(1'b0, 64'h0000_0003_0000_0004, 1000000, 64'h0000_0003_0000_0004, 100, 1000001);
		drive_pair(1'b0, 64'h0000_0003_0000_0005, 1000000, 64'h0000_0003_0000_0005,
		           32'hFFFF_FFF0, 3000001);
		drive_pair(1'b0, 64'h0F0F_0F0F_F0F0_F0F0, '1, 64'h0F0F_0F0F_F0F0_F0F0, $urandom, '1);
		drive_pair(1'b0, '1, '1, '1, '1, 64);
		drive_pair(1'b1, 64'h0000_0001_0000_0000, 7, 64'h0000_0001_0000_0000, 0, 7);
		drive_pair(1'b0, 64'h0000_0001_0000_0001, 3, 64'h0000_0001_0000_0001, 9, 4);
		drive_pair(1'b1, 64'd1, 1, 64'd2, 0, 1);
		drive_pair(1'b0, 64'd2, 1, 64'd2, 0, 1);
		drive_pair(1'b0, 64'd3, 2, 64'd3, 40, 6);

		for (phase = 0; phase < 8; phase++) begin
			set_limit(limits[phase]);
			send_idle = (phase % 4 == 1) ? 86 : (phase % 4 == 3) ? 20 : 0;
			recv_stall = (phase % 4 == 2) ? 86 : (phase % 4 == 3) ? 20 : 0;
			run_phase(PHASE_STEPS);
		end

		wait_drained();
		repeat (60) @(negedge clk);
		$display("tb: %0d steps sent over 8 threshold settings, zero and full range included,",
		         steps_sent);
		$display("tb: %0d results checked, %0d groups split, %0d of them capped at %0d parts",
		         result_count, split_count, capped_count, PARTS_MAX);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
